// File: hw/rtl/cit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cit_pkg
// shared types, codes and defaults of the case interval table
// ----------------------------------------------------------------------------
package cit_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam logic [1:0] CMD_INS_VALUE = 2'd0;
    localparam logic [1:0] CMD_INS_RANGE = 2'd1;
    localparam logic [1:0] CMD_QUERY     = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } cit_state_t;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic decide;
    } cit_ctrl_t;

    typedef struct packed {
        logic count_zero;
        logic last_rd;
    } cit_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/case_interval_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// case_interval_table
// table of non-overlapping signed intervals with insert and overlap query
// ----------------------------------------------------------------------------
// flow: load, scan of the stored entries one after another, drain, decide;
//   an empty table skips scan and drain; done is registered from decide
// throughput: next transfer accepted in the cycle of the done strobe
// done is a one-cycle strobe, result held till next decide; no receiver stall
// reset clears entry count and control; entry contents are unset until written
module case_interval_table
    import cit_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  cmd,
    input  wire logic signed [31:0] range_start,
    input  wire logic signed [31:0] range_end,
    output logic                    done,
    output logic             [1:0]  status,
    output logic             [3:0]  slot,
    output logic                    extended
);

    cit_ctrl_t ctrl;
    cit_stat_t stat;

    cit_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    cit_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cmd         (cmd),
        .range_start (range_start),
        .range_end   (range_end),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .extended    (extended)
    );

endmodule
`default_nettype wire

// File: hw/rtl/cit_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cit_ctrl
// sequencer: load, scan of stored entries, drain, decide and write
// ----------------------------------------------------------------------------
module cit_ctrl
    import cit_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire cit_stat_t stat,
    output cit_ctrl_t      ctrl,
    output logic           busy
);

    cit_state_t state_reg;
    cit_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = stat.count_zero ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.last_rd)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            S_SCAN:
            begin
                ctrl.scan_rd = 1'b1;
            end
            S_DRAIN:
            begin
                ctrl = '0;
            end
            S_DECIDE:
            begin
                ctrl.decide = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> busy)
        else $error("accepted transfer did not raise busy");
    a_decide_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.decide |=> !busy)
        else $error("controller not idle after decide");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.load, ctrl.scan_rd, ctrl.decide}))
        else $error("more than one datapath command at once");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/cit_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cit_dp
// entry memory, scan compare, decision and registered result
// ----------------------------------------------------------------------------
module cit_dp
    import cit_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cit_ctrl_t          ctrl,
    input  wire logic        [1:0]  cmd,
    input  wire logic signed [31:0] range_start,
    input  wire logic signed [31:0] range_end,
    output cit_stat_t               stat,
    output logic                    done,
    output logic             [1:0]  status,
    output logic             [3:0]  slot,
    output logic                    extended
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic signed [31:0] mem_low   [MAX_ENTRIES];
    logic signed [31:0] mem_high  [MAX_ENTRIES];
    logic               mem_dense [MAX_ENTRIES];

    logic        [1:0]       cmd_reg;
    logic signed [31:0]      s_reg;
    logic signed [31:0]      e_reg;
    logic        [CNT_W-1:0] count_reg;
    logic        [CNT_W-1:0] count_next;
    logic        [IDX_W-1:0] rd_idx_reg;
    logic        [IDX_W-1:0] rd_idx_d_reg;
    logic                    rd_valid_reg;
    logic signed [31:0]      rd_low_reg;
    logic signed [31:0]      rd_high_reg;
    logic                    rd_dense_reg;
    logic                    overlap_reg;
    logic                    match_reg;
    logic                    match_low_reg;
    logic        [IDX_W-1:0] match_idx_reg;

    logic                    done_reg;
    logic        [1:0]       status_reg;
    logic        [3:0]       slot_reg;
    logic                    ext_reg;

    logic        [1:0]       status_next;
    logic        [3:0]       slot_next;
    logic                    ext_next;

    logic signed [32:0]      s33;
    logic signed [32:0]      low_m1;
    logic signed [32:0]      high_p1;
    logic                    hit;
    logic                    adj_low;
    logic                    adj_high;

    logic                    we_low;
    logic                    we_high;
    logic                    we_dense;
    logic        [IDX_W-1:0] wr_addr;
    logic signed [31:0]      wr_low;
    logic signed [31:0]      wr_high;
    logic signed [31:0]      ord_low;
    logic signed [31:0]      ord_high;
    logic                    is_ins;
    logic                    full;

    // scan compare on registered read data
    always_comb
    begin
        s33      = {s_reg[31], s_reg};
        low_m1   = {rd_low_reg[31], rd_low_reg} - 33'sd1;
        high_p1  = {rd_high_reg[31], rd_high_reg} + 33'sd1;
        hit      = (rd_low_reg <= e_reg) && (s_reg <= rd_high_reg);
        adj_low  = rd_dense_reg && (s33 == low_m1);
        adj_high = rd_dense_reg && (s33 == high_p1);
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.last_rd    = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    // decision
    always_comb
    begin
        is_ins      = (cmd_reg == CMD_INS_VALUE) || (cmd_reg == CMD_INS_RANGE);
        full        = (count_reg == CNT_W'(MAX_ENTRIES));
        ord_low     = (s_reg > e_reg) ? e_reg : s_reg;
        ord_high    = (s_reg > e_reg) ? s_reg : e_reg;
        status_next = ST_DONE;
        slot_next   = '0;
        ext_next    = 1'b0;
        count_next  = count_reg;
        we_low      = 1'b0;
        we_high     = 1'b0;
        we_dense    = 1'b0;
        wr_addr     = count_reg[IDX_W-1:0];
        wr_low      = ord_low;
        wr_high     = ord_high;
        if (overlap_reg)
        begin
            status_next = ST_OVERLAP;
        end
        else if ((cmd_reg == CMD_INS_VALUE) && match_reg)
        begin
            we_low    = match_low_reg;
            we_high   = !match_low_reg;
            wr_addr   = match_idx_reg;
            wr_low    = s_reg;
            wr_high   = s_reg;
            slot_next = 4'(match_idx_reg);
            ext_next  = 1'b1;
        end
        else if (is_ins)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                we_low     = 1'b1;
                we_high    = 1'b1;
                we_dense   = 1'b1;
                slot_next  = 4'(count_reg[IDX_W-1:0]);
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (ctrl.decide && we_low)
        begin
            mem_low[wr_addr] <= wr_low;
        end
        if (ctrl.decide && we_high)
        begin
            mem_high[wr_addr] <= wr_high;
        end
        if (ctrl.decide && we_dense)
        begin
            mem_dense[wr_addr] <= (ord_low == ord_high);
        end
        if (ctrl.scan_rd)
        begin
            rd_low_reg   <= mem_low[rd_idx_reg];
            rd_high_reg  <= mem_high[rd_idx_reg];
            rd_dense_reg <= mem_dense[rd_idx_reg];
            rd_idx_d_reg <= rd_idx_reg;
        end
    end

    // operands and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
            s_reg   <= range_start;
            e_reg   <= (cmd == CMD_INS_VALUE) ? range_start : range_end;
        end
        if (ctrl.decide)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            ext_reg    <= ext_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            overlap_reg   <= 1'b0;
            match_reg     <= 1'b0;
            match_low_reg <= 1'b0;
            match_idx_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg     <= ctrl.decide;
            rd_valid_reg <= ctrl.scan_rd;
            if (ctrl.decide)
            begin
                count_reg <= count_next;
            end
            if (ctrl.load)
            begin
                rd_idx_reg  <= '0;
                overlap_reg <= 1'b0;
                match_reg   <= 1'b0;
            end
            else if (ctrl.scan_rd)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            if (rd_valid_reg)
            begin
                if (hit)
                begin
                    overlap_reg <= 1'b1;
                end
                if (!match_reg && (adj_low || adj_high))
                begin
                    match_reg     <= 1'b1;
                    match_low_reg <= adj_low;
                    match_idx_reg <= rd_idx_d_reg;
                end
            end
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign slot     = slot_reg;
    assign extended = ext_reg;

`ifndef SYNTHESIS
    a_done_follows_decide: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.decide |=> done)
        else $error("result strobe missing after decide");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");
    a_ext_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && extended) |-> (status == ST_DONE))
        else $error("extended transfer with non-done status");
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (count_reg == CNT_W'(MAX_ENTRIES)))
        else $error("full status while table has room");
`endif

endmodule
`default_nettype wire

// File: verif/tb_case_interval_table.sv
// ----------------------------------------------------------------------------
// tb_case_interval_table
// self-checking bench for the case interval table: a directed opening on an
// empty table, then random value, range, query and spare commands with an in-bench
// table model predicting status, slot and grow flag of every transfer
// ----------------------------------------------------------------------------
module tb_case_interval_table;
    timeunit 1ns;
    timeprecision 1ps;
    import cit_pkg::*;

    localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 800;
    localparam int MISMATCH_SHOWN = 10;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 12;
    localparam int ANCHOR_KEEP = 48;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] arg_a;
        logic signed [31:0] arg_b;
        int                 gap_pct;
    } table_cmd_t;

    typedef struct {
        int         tag;
        logic [1:0] status;
        logic [3:0] slot;
        logic       extended;
    } table_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic        [1:0]  cmd = CMD_INS_VALUE;
    logic signed [31:0] range_start = '0;
    logic signed [31:0] range_end = '0;
    logic               busy;
    logic               done;
    logic        [1:0]  status;
    logic        [3:0]  slot;
    logic               extended;

    // bench copy of the interval table
    logic signed [31:0] tbl_low [TABLE_DEPTH];
    logic signed [31:0] tbl_high [TABLE_DEPTH];
    logic               tbl_dense [TABLE_DEPTH];
    int                 tbl_count = 0;

    table_cmd_t         pending_cmds[$];
    table_result_t      expected_results[$];
    logic signed [31:0] anchors[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_errors = 0;
    int n_shown = 0;
    int n_stored = 0;
    int n_grown = 0;
    int n_overlap = 0;
    int n_full = 0;
    int n_query = 0;

    case_interval_table #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .range_start (range_start),
        .range_end   (range_end),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .extended    (extended)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // overlap test uses the bounds as given, never reordered
    function automatic bit range_hits(longint lo, longint hi);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (longint'(tbl_low[i]) <= hi && lo <= longint'(tbl_high[i]))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic table_result_t apply_table_cmd(logic [1:0] op,
                                                      logic signed [31:0] a,
                                                      logic signed [31:0] b);
        table_result_t r;
        longint        sa;
        longint        sb;
        longint        t;
        sa = longint'(a);
        sb = longint'(b);
        r.tag = 0;
        r.status = ST_DONE;
        r.slot = '0;
        r.extended = 1'b0;
        if (op == CMD_INS_VALUE)
        begin
            if (range_hits(sa, sa))
            begin
                r.status = ST_OVERLAP;
                return r;
            end
            // first dense neighbor in slot order grows, no wrap at the extremes
            for (int i = 0; i < tbl_count; i++)
            begin
                if (tbl_dense[i] && sa == longint'(tbl_low[i]) - 1)
                begin
                    tbl_low[i] = a;
                    r.slot = 4'(i);
                    r.extended = 1'b1;
                    return r;
                end
                if (tbl_dense[i] && sa == longint'(tbl_high[i]) + 1)
                begin
                    tbl_high[i] = a;
                    r.slot = 4'(i);
                    r.extended = 1'b1;
                    return r;
                end
            end
            sb = sa;
        end
        else if (op == CMD_INS_RANGE)
        begin
            if (range_hits(sa, sb))
            begin
                r.status = ST_OVERLAP;
                return r;
            end
        end
        else
        begin
            if (range_hits(sa, sb))
                r.status = ST_OVERLAP;
            return r;
        end
        if (tbl_count >= TABLE_DEPTH)
        begin
            r.status = ST_FULL;
            return r;
        end
        if (sa > sb)
        begin
            t = sa;
            sa = sb;
            sb = t;
        end
        tbl_low[tbl_count] = 32'(sa);
        tbl_high[tbl_count] = 32'(sb);
        tbl_dense[tbl_count] = (sa == sb);
        r.slot = 4'(tbl_count);
        tbl_count++;
        return r;
    endfunction

    task automatic queue_cmd(logic [1:0] op, logic signed [31:0] a,
                             logic signed [31:0] b, int gap);
        table_cmd_t c;
        c.op = op;
        c.arg_a = a;
        c.arg_b = b;
        c.gap_pct = gap;
        pending_cmds = {pending_cmds, c};
        if (op == CMD_INS_VALUE)
        begin
            anchors = {anchors, a};
            if (anchors.size() > ANCHOR_KEEP)
                void'(anchors.pop_front());
        end
    endtask

    // mostly values next to or on earlier values so dense entries keep growing
    task automatic queue_random_cmd(int gap);
        int                 pick;
        int                 k;
        logic signed [31:0] base;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] t;
        pick = $urandom_range(99);
        k = (anchors.size() > 0) ? $urandom_range(anchors.size() - 1) : 0;
        base = (anchors.size() > 0) ? anchors[k] : $urandom;
        b = $urandom;
        if (pick < 40)
        begin
            a = ($urandom_range(1) == 1) ? base + 32'sd1 : base - 32'sd1;
            queue_cmd(CMD_INS_VALUE, a, b, gap);
        end
        else if (pick < 50)
        begin
            queue_cmd(CMD_INS_VALUE, base, b, gap);
        end
        else if (pick < 62)
        begin
            a = $urandom;
            queue_cmd(CMD_INS_VALUE, a, b, gap);
        end
        else if (pick < 80)
        begin
            a = (pick < 72) ? 32'($urandom) : base + 32'($urandom_range(4, 1));
            b = a + 32'($urandom_range(6, 0));
            if ($urandom_range(1) == 1)
            begin
                t = a;
                a = b;
                b = t;
            end
            queue_cmd(CMD_INS_RANGE, a, b, gap);
        end
        else if (pick < 92)
        begin
            if ($urandom_range(1) == 1)
            begin
                a = base - 32'sd1;
                b = base + 32'sd1;
            end
            else
            begin
                a = $urandom;
            end
            queue_cmd(CMD_QUERY, a, b, gap);
        end
        else
        begin
            a = $urandom;
            queue_cmd(CMD_SPARE, a, b, gap);
        end
    endtask

    // driver: predict at each accepted transfer, then offer the next command
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        table_result_t res;
        table_cmd_t    nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= CMD_INS_VALUE;
            range_start <= '0;
            range_end <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                res = apply_table_cmd(cmd, range_start, range_end);
                res.tag = n_accepted;
                n_accepted++;
                expected_results = {expected_results, res};
                if (cmd == CMD_QUERY || cmd == CMD_SPARE)
                    n_query++;
                else if (res.extended)
                    n_grown++;
                else if (res.status == ST_DONE)
                    n_stored++;
                if (res.status == ST_OVERLAP)
                    n_overlap++;
                else if (res.status == ST_FULL)
                    n_full++;
            end
            if (!start || !busy)
            begin
                if (pending_cmds.size() > 0 &&
                    $urandom_range(99) >= pending_cmds[0].gap_pct)
                begin
                    nxt = pending_cmds.pop_front();
                    start <= 1'b1;
                    cmd <= nxt.op;
                    range_start <= nxt.arg_a;
                    range_end <= nxt.arg_b;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every done strobe is checked against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        table_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                n_errors++;
                if (n_shown < MISMATCH_SHOWN)
                begin
                    n_shown++;
                    $display("[%0t] unexpected result: status %0d slot %0d ext %0d",
                             $realtime, status, slot, extended);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status || slot !== want.slot ||
                    extended !== want.extended)
                begin
                    n_errors++;
                    if (n_shown < MISMATCH_SHOWN)
                    begin
                        n_shown++;
                        $display("[%0t] transfer %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 $realtime, want.tag, want.status, want.slot,
                                 want.extended, status, slot, extended);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int gap;
        // empty table, growing at both ends, non-dense neighbors
        queue_cmd(CMD_QUERY, -32'sd10, 32'sd10, 24);
        queue_cmd(CMD_INS_VALUE, 32'sd0, 32'sd0, 24);
        queue_cmd(CMD_INS_VALUE, 32'sd1, VAL_MAX, 24);
        queue_cmd(CMD_INS_VALUE, -32'sd1, VAL_MIN, 24);
        queue_cmd(CMD_INS_VALUE, 32'sd0, 32'sd0, 24);
        queue_cmd(CMD_INS_RANGE, 32'sd100, 32'sd90, 24);
        queue_cmd(CMD_INS_VALUE, 32'sd101, 32'sd0, 24);
        queue_cmd(CMD_INS_RANGE, 32'sd95, 32'sd92, 24);
        queue_cmd(CMD_INS_RANGE, 32'sd200, 32'sd150, 24);
        queue_cmd(CMD_QUERY, 32'sd99, 32'sd91, 24);
        queue_cmd(CMD_SPARE, -32'sd5, -32'sd3, 24);
        // extremes, adjacency must not wrap
        queue_cmd(CMD_INS_VALUE, VAL_MAX, 32'sd0, 24);
        queue_cmd(CMD_INS_VALUE, VAL_MAX - 32'sd1, 32'sd0, 24);
        queue_cmd(CMD_INS_VALUE, VAL_MIN, 32'sd0, 24);
        queue_cmd(CMD_INS_VALUE, VAL_MIN + 32'sd1, 32'sd0, 24);
        queue_cmd(CMD_INS_RANGE, 32'sd5000, 32'sd5000, 24);
        queue_cmd(CMD_INS_VALUE, 32'sd5001, 32'sd0, 24);
        queue_cmd(CMD_QUERY, VAL_MIN, VAL_MAX, 24);
        queue_cmd(CMD_INS_RANGE, VAL_MIN, VAL_MAX, 24);
        queue_cmd(CMD_QUERY, VAL_MAX, VAL_MIN, 24);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i < RANDOM_ITEMS / 3)
                gap = 24;
            else if (i < 2 * RANDOM_ITEMS / 3)
                gap = 82;
            else
                gap = 0;
            queue_random_cmd(gap);
        end
        n_queued = pending_cmds.size();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (n_accepted < n_queued)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d transfers: %0d stored, %0d grown, %0d queries",
                 n_accepted, n_stored, n_grown, n_query);
        $display("%0d overlaps, %0d full, table ended with %0d entries, %0d mismatches",
                 n_overlap, n_full, tbl_count, n_errors);
        if (n_errors == 0 && expected_results.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
